// ===== src/pcxrle_pkg.sv =====
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared constants and types for the PCX run-length scanline decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int POS_W       = 16;
    localparam int PLANES_W    = 3;
    localparam int RUN_W       = 6;
    localparam int STRIDE_W    = POS_W + PLANES_W;
    localparam int COLOFF_W    = POS_W + 2;

    localparam logic [1:0]          RUN_MARK   = 2'b11;
    localparam logic [PLANES_W-1:0] MAX_PLANES = PLANES_W'(4);

    localparam logic [CFG_IDX_W-1:0] CFG_LINE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEPT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PLANES = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = CFG_IDX_W'(3);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PREP1 = 5'b00010,
        S_PREP2 = 5'b00100,
        S_RUN   = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

endpackage

// ===== src/pcxrle_in_if.sv =====
// ----------------------------------------------------------------------------
// pcxrle_in_if
// Coded byte channel: valid/ready handshake with the compressed byte payload.
// ----------------------------------------------------------------------------
interface pcxrle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] coded_byte;
    logic       new_image;

    modport source (output valid, output coded_byte, output new_image, input ready);
    modport sink   (input valid, input coded_byte, input new_image, output ready);
endinterface

// ===== src/pcxrle_out_if.sv =====
// ----------------------------------------------------------------------------
// pcxrle_out_if
// Decoded pixel channel: valid/ready handshake with pixel byte and offset.
// ----------------------------------------------------------------------------
interface pcxrle_out_if import pcxrle_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [7:0]             pixel_byte;
    logic [OFFSET_BITS-1:0] image_offset;
    logic                   last;

    modport source (output valid, output pixel_byte, output image_offset, output last,
                    input ready);
    modport sink   (input valid, input pixel_byte, input image_offset, input last,
                    output ready);
endinterface

// ===== src/pcx_rle_scanline_decoder_top.sv =====
// Sequence: a run marker, zero-length run or ignored byte is taken in S_IDLE alone; a literal
// or run value byte passes through accept, the setup states S_PREP1 and S_PREP2 that form
// the row and column offsets, one S_RUN step per decoded byte and a flush, skipped if none is kept.
// Throughput: one decoded byte per cycle from the shared position stepper while out is ready.
// Reset: synchronous, active low; clears the position state and sets every
// configuration register to one.
// ----------------------------------------------------------------------------
// pcx_rle_scanline_decoder_top
// Decodes PCX run-length bytes and places each kept byte in the interleaved
// image by plane, column and row.
// ----------------------------------------------------------------------------
module pcx_rle_scanline_decoder_top import pcxrle_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pcxrle_in_if.sink             i_byte_ch,
    pcxrle_out_if.source          o_pix_ch
);

    t_state r_state, n_state;

    logic [POS_W-1:0]    r_cfg_line, r_cfg_kept, r_cfg_rows;
    logic [PLANES_W-1:0] r_cfg_planes;

    logic                r_pending, n_pending;
    logic [RUN_W-1:0]    r_run_len, n_run_len;
    logic [POS_W-1:0]    r_col, n_col;
    logic [1:0]          r_plane, n_plane;
    logic [POS_W-1:0]    r_row, n_row;
    logic                r_done, n_done;

    logic [RUN_W-1:0]       r_cnt, n_cnt;
    logic [7:0]             r_byte, n_byte;
    logic [STRIDE_W-1:0]    r_stride, n_stride;
    logic [COLOFF_W-1:0]    r_col_off, n_col_off;
    logic [OFFSET_BITS-1:0] r_row_base, n_row_base;

    logic                   r_pend_valid, n_pend_valid;
    logic [7:0]             r_pend_byte, n_pend_byte;
    logic [OFFSET_BITS-1:0] r_pend_off, n_pend_off;

    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_byte, n_out_byte;
    logic [OFFSET_BITS-1:0] r_out_off, n_out_off;
    logic                   r_out_last, n_out_last;

    logic [POS_W-1:0]    line_eff, kept_eff, rows_eff;
    logic [PLANES_W-1:0] planes_eff;
    logic                accept, out_free, can_step, emit, col_wrap, row_wrap, step_end;
    logic [POS_W:0]      col_inc;
    logic [PLANES_W-1:0] plane_inc;
    logic [POS_W-1:0]    row_inc;
    logic [OFFSET_BITS-1:0] cur_off;
    logic [POS_W+STRIDE_W-1:0] row_prod;

    always_comb begin
        line_eff   = (r_cfg_line == '0) ? POS_W'(1) : r_cfg_line;
        kept_eff   = (r_cfg_kept < line_eff) ? r_cfg_kept : line_eff;
        rows_eff   = (r_cfg_rows == '0) ? POS_W'(1) : r_cfg_rows;
        if (r_cfg_planes == '0) begin
            planes_eff = PLANES_W'(1);
        end else if (r_cfg_planes > MAX_PLANES) begin
            planes_eff = MAX_PLANES;
        end else begin
            planes_eff = r_cfg_planes;
        end
    end

    assign i_byte_ch.ready     = (r_state == S_IDLE);
    assign accept              = i_byte_ch.valid && (r_state == S_IDLE);
    assign out_free            = !r_out_valid || o_pix_ch.ready;
    assign can_step            = out_free || !r_pend_valid;

    assign emit      = (r_col < kept_eff);
    assign col_inc   = {1'b0, r_col} + (POS_W+1)'(1);
    assign col_wrap  = (col_inc >= {1'b0, line_eff});
    assign plane_inc = {1'b0, r_plane} + PLANES_W'(1);
    assign row_wrap  = col_wrap && (plane_inc >= planes_eff);
    assign row_inc   = r_row + POS_W'(1);
    assign step_end  = (r_cnt == RUN_W'(1)) || row_wrap;
    assign cur_off   = r_row_base + OFFSET_BITS'(r_col_off) + OFFSET_BITS'(r_plane);
    assign row_prod  = (POS_W+STRIDE_W)'(r_row) * (POS_W+STRIDE_W)'(r_stride);

    always_comb begin
        n_state      = r_state;
        n_pending    = r_pending;
        n_run_len    = r_run_len;
        n_col        = r_col;
        n_plane      = r_plane;
        n_row        = r_row;
        n_done       = r_done;
        n_cnt        = r_cnt;
        n_byte       = r_byte;
        n_stride     = r_stride;
        n_col_off    = r_col_off;
        n_row_base   = r_row_base;
        n_pend_valid = r_pend_valid;
        n_pend_byte  = r_pend_byte;
        n_pend_off   = r_pend_off;
        n_out_valid  = r_out_valid && !o_pix_ch.ready;
        n_out_byte   = r_out_byte;
        n_out_off    = r_out_off;
        n_out_last   = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_byte_ch.new_image) begin
                        n_pending = 1'b0;
                        n_run_len = '0;
                        n_col     = '0;
                        n_plane   = '0;
                        n_row     = '0;
                        n_done    = 1'b0;
                    end
                    n_byte = i_byte_ch.coded_byte;
                    if (!(r_done && !i_byte_ch.new_image)) begin
                        if (r_pending && !i_byte_ch.new_image) begin
                            n_pending = 1'b0;
                            n_run_len = '0;
                            n_cnt     = r_run_len;
                            if (r_run_len != '0) begin
                                n_state = S_PREP1;
                            end
                        end else if (i_byte_ch.coded_byte[7:6] == RUN_MARK) begin
                            n_pending = 1'b1;
                            n_run_len = i_byte_ch.coded_byte[RUN_W-1:0];
                        end else begin
                            n_cnt   = RUN_W'(1);
                            n_state = S_PREP1;
                        end
                    end
                end
            end
            S_PREP1: begin
                n_stride  = STRIDE_W'(kept_eff) * STRIDE_W'(planes_eff);
                n_col_off = COLOFF_W'(r_col) * COLOFF_W'(planes_eff);
                n_state   = S_PREP2;
            end
            S_PREP2: begin
                n_row_base = row_prod[OFFSET_BITS-1:0];
                n_state    = S_RUN;
            end
            S_RUN: begin
                if (can_step) begin
                    if (emit) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_byte  = r_pend_byte;
                            n_out_off   = r_pend_off;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_byte  = r_byte;
                        n_pend_off   = cur_off;
                    end
                    if (col_wrap) begin
                        n_col     = '0;
                        n_col_off = '0;
                        if (row_wrap) begin
                            n_plane = '0;
                            n_row   = row_inc;
                            n_done  = (row_inc == '0) || (row_inc >= rows_eff);
                        end else begin
                            n_plane = plane_inc[1:0];
                        end
                    end else begin
                        n_col     = col_inc[POS_W-1:0];
                        n_col_off = r_col_off + COLOFF_W'(planes_eff);
                    end
                    n_cnt = r_cnt - RUN_W'(1);
                    if (step_end) begin
                        n_state = (emit || r_pend_valid) ? S_FLUSH : S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = r_pend_byte;
                    n_out_off    = r_pend_off;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_line   <= POS_W'(1);
            r_cfg_kept   <= POS_W'(1);
            r_cfg_planes <= PLANES_W'(1);
            r_cfg_rows   <= POS_W'(1);
            r_pending    <= 1'b0;
            r_run_len    <= '0;
            r_col        <= '0;
            r_plane      <= '0;
            r_row        <= '0;
            r_done       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pending    <= n_pending;
            r_run_len    <= n_run_len;
            r_col        <= n_col;
            r_plane      <= n_plane;
            r_row        <= n_row;
            r_done       <= n_done;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LINE:   r_cfg_line   <= i_cfg_data;
                    CFG_KEPT:   r_cfg_kept   <= i_cfg_data;
                    CFG_PLANES: r_cfg_planes <= i_cfg_data[PLANES_W-1:0];
                    CFG_ROWS:   r_cfg_rows   <= i_cfg_data;
                    default:    r_cfg_rows   <= r_cfg_rows;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_byte      <= n_byte;
        r_stride    <= n_stride;
        r_col_off   <= n_col_off;
        r_row_base  <= n_row_base;
        r_pend_byte <= n_pend_byte;
        r_pend_off  <= n_pend_off;
        r_out_byte  <= n_out_byte;
        r_out_off   <= n_out_off;
        r_out_last  <= n_out_last;
    end

    assign o_pix_ch.valid        = r_out_valid;
    assign o_pix_ch.pixel_byte   = r_out_byte;
    assign o_pix_ch.image_offset = r_out_off;
    assign o_pix_ch.last         = r_out_last;

endmodule

// ===== tb/sv/pcx_rle_scanline_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_scanline_decoder_top_tb
// Self-checking bench for the PCX run-length scanline decoder. A scoreboard
// class tracks run state, plane, column and row. For every accepted coded byte
// it predicts the kept pixel bytes, their interleaved offsets and the last
// flag. A short directed pass covers literals, zero-length runs, runs cut at
// the scanline end, input after the final row and restarts. Random passes
// follow under several register settings, extremes included. Both channels
// idle at random. The receiver holds off once for a long stretch, and the
// sender drains once midway through a random pass and before every register change.
// ----------------------------------------------------------------------------
module pcx_rle_scanline_decoder_top_tb;
    import pcxrle_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int SETTLE_CYCLES  = 80;
    localparam int HOLD_CYCLES    = 500;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [7:0]             pixel;
        logic [OFFSET_BITS-1:0] offset;
        logic                   last;
    } pixel_rec_t;

    class pcx_scoreboard;
        pixel_rec_t  expected_q[$];
        int unsigned line_cfg;
        int unsigned kept_cfg;
        int unsigned planes_cfg;
        int unsigned rows_cfg;
        bit          run_pending;
        int unsigned run_len;
        int unsigned col;
        int unsigned plane;
        int unsigned row;
        bit          image_done;
        int unsigned errors = 0;

        function void clear_position();
            run_pending = 1'b0;
            run_len     = 0;
            col         = 0;
            plane       = 0;
            row         = 0;
            image_done  = 1'b0;
        endfunction

        function void reset();
            line_cfg   = 1;
            kept_cfg   = 1;
            planes_cfg = 1;
            rows_cfg   = 1;
            clear_position();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LINE:   line_cfg   = data;
                CFG_KEPT:   kept_cfg   = data;
                CFG_PLANES: planes_cfg = data[PLANES_W-1:0];
                CFG_ROWS:   rows_cfg   = data;
                default: ;
            endcase
        endfunction

        function void note_input(logic [7:0] code, logic new_img);
            int unsigned       count;
            int unsigned       line_len;
            int unsigned       kept;
            int unsigned       planes;
            int unsigned       rows;
            longint unsigned   off;
            bit                line_end;
            bit                have_rec;
            pixel_rec_t        rec;
            if (new_img)
                clear_position();
            if (image_done)
                return;
            if (run_pending) begin
                count       = run_len;
                run_pending = 1'b0;
                run_len     = 0;
            end else if (code[7:6] == RUN_MARK) begin
                run_len     = code[5:0];
                run_pending = 1'b1;
                return;
            end else begin
                count = 1;
            end
            line_len = (line_cfg == 0) ? 1 : line_cfg;
            kept     = (kept_cfg < line_len) ? kept_cfg : line_len;
            planes   = (planes_cfg == 0) ? 1 : ((planes_cfg > 4) ? 4 : planes_cfg);
            rows     = (rows_cfg == 0) ? 1 : rows_cfg;
            have_rec = 1'b0;
            for (int i = 0; i < count; i++) begin
                line_end = 1'b0;
                if (col < kept) begin
                    if (have_rec)
                        expected_q.push_back(rec);
                    off = longint'(row) * kept * planes + longint'(col) * planes + plane;
                    rec.pixel  = code;
                    rec.offset = off[OFFSET_BITS-1:0];
                    rec.last   = 1'b0;
                    have_rec   = 1'b1;
                end
                col++;
                if (col >= line_len) begin
                    col = 0;
                    plane++;
                    if (plane >= planes) begin
                        plane    = 0;
                        row      = (row + 1) & 32'hFFFF;
                        line_end = 1'b1;
                        if (row == 0 || row >= rows)
                            image_done = 1'b1;
                    end
                end
                if (line_end)
                    break;
            end
            if (have_rec) begin
                rec.last = 1'b1;
                expected_q.push_back(rec);
            end
        endfunction

        function bit busy();
            return expected_q.size() != 0;
        endfunction

        function void check_result(logic [7:0] pix, logic [OFFSET_BITS-1:0] off, logic last);
            pixel_rec_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected pixel %h offset %h last %b", $time, pix, off, last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (pix !== want.pixel) begin
                $display("%0t: pixel mismatch expected %h actual %h", $time, want.pixel, pix);
                errors++;
            end
            if (off !== want.offset) begin
                $display("%0t: offset mismatch expected %h actual %h", $time, want.offset, off);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last mismatch expected %b actual %b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pcxrle_in_if  byte_ch ();
    pcxrle_out_if pix_ch ();

    pcx_rle_scanline_decoder_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_byte_ch  (byte_ch),
        .o_pix_ch   (pix_ch)
    );

    pcx_scoreboard pix_sb = new;

    int burst_left   = 0;
    int idle_cycles  = 0;
    bit hold_req     = 1'b0;
    bit hold_done    = 1'b0;

    localparam logic [8:0] DIRECTED [18] = '{
        {1'b1, 8'h00}, {1'b0, 8'hBF}, {1'b0, 8'hC0}, {1'b0, 8'hAA},
        {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hC2}, {1'b0, 8'hC3},
        {1'b0, 8'h7E}, {1'b0, 8'hC8}, {1'b0, 8'h01}, {1'b0, 8'hC5},
        {1'b0, 8'h02}, {1'b0, 8'h12}, {1'b0, 8'hC1}, {1'b1, 8'hC4},
        {1'b0, 8'h55}, {1'b0, 8'h00}
    };

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    task automatic send_code(input logic [7:0] code, input logic new_img);
        byte_ch.valid      <= 1'b1;
        byte_ch.coded_byte <= code;
        byte_ch.new_image  <= new_img;
        @(posedge i_clk);
        while (!byte_ch.ready)
            @(posedge i_clk);
        pix_sb.note_input(code, new_img);
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic drain();
        byte_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pix_sb.busy());
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        pix_sb.write_reg(idx, data);
    endtask

    task automatic program_cfg(input logic [15:0] line_len, input logic [15:0] kept,
                               input logic [15:0] planes, input logic [15:0] rows);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_cfg(CFG_LINE, line_len);
        write_cfg(CFG_KEPT, kept);
        write_cfg(CFG_PLANES, planes);
        write_cfg(CFG_ROWS, rows);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [5:0] pick_run_count();
        case ($urandom_range(0, 7))
            0:       return 6'd0;
            1:       return 6'd63;
            2:       return 6'($urandom_range(1, 63));
            default: return 6'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic send_random(input int n_items, input bit pause_midway);
        int         sent;
        int         kind;
        bit         first;
        bit         paused;
        logic [7:0] code;
        logic       new_img;
        sent   = 0;
        first  = 1'b1;
        paused = 1'b0;
        while (sent < n_items) begin
            if (pause_midway && !paused && sent >= n_items / 2) begin
                paused = 1'b1;
                drain();
            end
            new_img = first || (pix_sb.image_done ? ($urandom_range(0, 7) != 0)
                                                  : ($urandom_range(0, 39) == 0));
            first = 1'b0;
            kind  = $urandom_range(0, 9);
            if (kind < 6) begin
                code = {RUN_MARK, pick_run_count()};
                if (!(pix_sb.image_done && !new_img))
                    sent++;
                pace();
                send_code(code, new_img);
                if (!pix_sb.image_done)
                    sent++;
                pace();
                send_code(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                if (kind < 9)
                    code = 8'($urandom_range(0, 8'hBF));
                else begin
                    code    = 8'($urandom_range(0, 255));
                    new_img = new_img | 1'($urandom_range(0, 1));
                end
                if (!(pix_sb.image_done && !new_img))
                    sent++;
                pace();
                send_code(code, new_img);
            end
        end
    endtask

    initial begin
        int rx_cyc;
        rx_cyc = 0;
        pix_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pix_ch.valid && pix_ch.ready)
                pix_sb.check_result(pix_ch.pixel_byte, pix_ch.image_offset, pix_ch.last);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                pix_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            rx_cyc++;
            case ((rx_cyc / 64) % 4)
                0:       pix_ch.ready <= 1'b1;
                1:       pix_ch.ready <= 1'($urandom_range(0, 1));
                2:       pix_ch.ready <= ($urandom_range(0, 3) == 0);
                default: pix_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (pix_ch.valid && pix_ch.ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        byte_ch.valid      <= 1'b0;
        byte_ch.coded_byte <= 8'h00;
        byte_ch.new_image  <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_LINE;
        i_cfg_data         <= '0;
        i_rst_n            <= 1'b0;
        pix_sb.reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pace();
        send_code(8'h3F, 1'b0);
        pace();
        send_code(8'h40, 1'b0);
        pace();
        send_code(8'h80, 1'b1);

        program_cfg(16'd4, 16'd3, 16'd3, 16'd2);
        foreach (DIRECTED[i]) begin
            pace();
            send_code(DIRECTED[i][7:0], DIRECTED[i][8]);
        end

        program_cfg(16'd0, 16'd0, 16'd0, 16'd0);
        send_random(8, 1'b0);

        program_cfg(16'd5, 16'd3, 16'd3, 16'd3);
        hold_req = 1'b1;
        send_random(25, 1'b1);

        program_cfg(16'd6, 16'd9, 16'd4, 16'd2);
        send_random(20, 1'b0);

        program_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_random(10, 1'b0);

        program_cfg(16'd2, 16'd2, 16'd3, 16'd0);
        send_random(15, 1'b0);

        repeat (3) begin
            program_cfg(16'($urandom_range(1, 8)), 16'($urandom_range(0, 10)),
                        16'($urandom_range(0, 7)), 16'($urandom_range(0, 4)));
            send_random(15, 1'b0);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pix_sb.errors == 0 && !pix_sb.busy())
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
